[design/pcv_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the pid controller variants block
package pcv_pkg;

   typedef enum logic [1:0] {
      CMD_PLAIN    = 2'd0,
      CMD_SEPARATE = 2'd1,
      CMD_CLIP     = 2'd2,
      CMD_WEAKEN   = 2'd3
   } cmd_type;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN        = 3'd0,
      CSR_INTEG_GAIN       = 3'd1,
      CSR_DERIV_GAIN       = 3'd2,
      CSR_DEAD_BAND        = 3'd3,
      CSR_INTEGRAL_LIMIT   = 3'd4,
      CSR_PROP_TERM_LIMIT  = 3'd5,
      CSR_DERIV_TERM_LIMIT = 3'd6,
      CSR_DRIVE_LIMIT      = 3'd7
   } csr_type;

   // term lanes of the multiply datapath
   localparam int TERMS  = 3;
   localparam int TERM_P = 0;
   localparam int TERM_I = 1;
   localparam int TERM_D = 2;

   localparam int GAIN_W = 32;
   localparam int LIM_W  = 31;
   localparam int SUM_W  = 48;
   localparam int MAG_W  = 48;
   localparam int HALF_W = 24;
   localparam int PROD_W = HALF_W + GAIN_W;
   localparam int TMAG_W = 62;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

   // every term and partial sum saturates at +-2^61
   localparam logic [63:0]        TERM_CAP   = 64'h2000_0000_0000_0000;
   localparam logic signed [63:0] TERM_CAP_S = 64'sh2000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] setpoint;
      logic signed [31:0] feedback;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               clamped;
   } rsp_payload_type;

endpackage

[design/pid_controller_variants.sv]
`timescale 1ns / 1ps
// pid controller variants top level: positional pid in signed q16.16 with four
// anti-windup variants picked per item by cmd. The block takes one item every
// clock while the result is not stalled and returns its drive through eight
// pipeline registers and the result register. The error sum and last error close
// their loop in the fourth stage, one add-saturate-clip per cycle, which sets the
// rate of one item per clock. The three gain products are each split into two
// 24x32 partial products and joined in stage 7. Variant 3 looks at the previous
// drive; while that item is still in the pipeline its drive is known to be
// inside the current drive limit. A stalled result stops the pipeline only once
// every stage is full. Configuration writes are taken every cycle and should
// come only while no item is in flight.
module pid_controller_variants (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pcv_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pcv_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                        csr_wdata
);

   localparam int STAGES = 8;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] e;
      logic               le_db;
      logic               lt_db;
      logic               sep;
      logic               pos;
      logic               neg;
   } b_stage_type;

   // configuration registers
   logic [pcv_pkg::GAIN_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [pcv_pkg::LIM_W-1:0]  dead_band_ff, integral_limit_ff;
   logic [pcv_pkg::LIM_W-1:0]  prop_term_limit_ff, deriv_term_limit_ff, drive_limit_ff;

   // handshake
   logic [STAGES:1]   valid_ff;
   logic [STAGES+1:1] move;
   logic              rsp_valid_ff;

   // controller state
   logic signed [pcv_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic signed [31:0]               last_error_ff;
   logic signed [31:0]               last_drive_ff;

   // stage 1: input register
   pcv_pkg::req_payload_type req_ff;

   // stage 2: saturated error
   logic signed [32:0] diff_in;
   logic signed [31:0] a_e_in, a_e_ff;
   logic [1:0]         a_cmd_ff;

   // stage 3: deadband and threshold flags
   logic [31:0] a_mag;
   logic        zero_e, le_db, lt_db, gt_il;
   b_stage_type b_in, b_ff;

   // stage 4: error sum update
   logic                             pending, ld_le, ld_ge, acc;
   logic signed [31:0]               dl_s;
   logic signed [pcv_pkg::SUM_W-1:0] il_pos, il_neg;
   logic signed [pcv_pkg::SUM_W-1:0] sum_base, sum_sat, sum_acc, sum_clip, isum_in;
   logic signed [pcv_pkg::SUM_W:0]   sum_add;
   logic signed [32:0]               de_in;
   logic [1:0]                       c_cmd_ff;
   logic signed [31:0]               c_e_ff;
   logic signed [32:0]               c_de_ff;
   logic signed [pcv_pkg::SUM_W-1:0] c_isum_ff;

   // stage 5: operand magnitudes
   logic [31:0]                                       p_mag32;
   logic [32:0]                                       de_mag;
   logic [pcv_pkg::MAG_W-1:0]                         de_mag48;
   logic [pcv_pkg::TERMS-1:0][pcv_pkg::MAG_W-1:0]     d_mag_in, d_mag_ff;
   logic [pcv_pkg::TERMS-1:0]                         d_sign_in, d_sign_ff;
   logic [1:0]                                        d_cmd_ff;

   // stage 6: partial products
   logic [pcv_pkg::TERMS-1:0][pcv_pkg::GAIN_W-1:0]    gain;
   logic [pcv_pkg::TERMS-1:0][pcv_pkg::PROD_W-1:0]    e_lo_in, e_hi_in, e_lo_ff, e_hi_ff;
   logic [pcv_pkg::TERMS-1:0]                         e_sign_ff;
   logic [1:0]                                        e_cmd_ff;

   // stage 7: capped and clipped term magnitudes
   logic [pcv_pkg::TERMS-1:0][63:0]                   lim;
   logic [pcv_pkg::TERMS-1:0]                         lim_on;
   logic [pcv_pkg::TERMS-1:0][pcv_pkg::TMAG_W-1:0]    f_mag_in, f_mag_ff;
   logic [pcv_pkg::TERMS-1:0]                         f_sign_ff;

   // stage 8: p plus i
   logic signed [62:0] term_val [pcv_pkg::TERMS];
   logic signed [63:0] pi_sum;
   logic signed [62:0] g_pi_in, g_pi_ff, g_d_ff;

   // result register
   logic signed [63:0]       drv_sum, drv_lim;
   pcv_pkg::rsp_payload_type rsp_in, rsp_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff        <= '0;
         integ_gain_ff       <= '0;
         deriv_gain_ff       <= '0;
         dead_band_ff        <= '0;
         integral_limit_ff   <= '0;
         prop_term_limit_ff  <= '0;
         deriv_term_limit_ff <= '0;
         drive_limit_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (pcv_pkg::csr_type'(csr_index))
            pcv_pkg::CSR_PROP_GAIN:        prop_gain_ff        <= csr_wdata;
            pcv_pkg::CSR_INTEG_GAIN:       integ_gain_ff       <= csr_wdata;
            pcv_pkg::CSR_DERIV_GAIN:       deriv_gain_ff       <= csr_wdata;
            pcv_pkg::CSR_DEAD_BAND:        dead_band_ff        <= csr_wdata[30:0];
            pcv_pkg::CSR_INTEGRAL_LIMIT:   integral_limit_ff   <= csr_wdata[30:0];
            pcv_pkg::CSR_PROP_TERM_LIMIT:  prop_term_limit_ff  <= csr_wdata[30:0];
            pcv_pkg::CSR_DERIV_TERM_LIMIT: deriv_term_limit_ff <= csr_wdata[30:0];
            pcv_pkg::CSR_DRIVE_LIMIT:      drive_limit_ff      <= csr_wdata[30:0];
            default:                       drive_limit_ff      <= drive_limit_ff;
         endcase
      end
   end

   // ------------------------------------------------------------- handshake
   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      move[STAGES+1] = !rsp_valid_ff || !rsp_stall;
      for (int k = STAGES; k >= 1; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
   end

   assign req_stall   = !move[1];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (move[1]) valid_ff[1] <= req_valid;
         for (int k = 2; k <= STAGES; k++) begin
            if (move[k]) valid_ff[k] <= valid_ff[k-1];
         end
         if (move[STAGES+1]) rsp_valid_ff <= valid_ff[STAGES];
      end
   end

   // --------------------------------------------------------------- stage 2
   assign diff_in = 33'(req_ff.setpoint) - 33'(req_ff.feedback);

   always_comb begin
      if (diff_in[32] != diff_in[31]) begin
         a_e_in = diff_in[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         a_e_in = diff_in[31:0];
      end
   end

   // --------------------------------------------------------------- stage 3
   assign a_mag = a_e_ff[31] ? (32'(~a_e_ff) + 32'd1) : 32'(a_e_ff);
   assign le_db = a_mag <= {1'b0, dead_band_ff};
   assign lt_db = a_mag < {1'b0, dead_band_ff};
   assign gt_il = a_mag > {1'b0, integral_limit_ff};
   assign zero_e = (a_cmd_ff == pcv_pkg::CMD_PLAIN || a_cmd_ff == pcv_pkg::CMD_SEPARATE)
                   && le_db;

   always_comb begin
      b_in.cmd   = a_cmd_ff;
      b_in.e     = zero_e ? 32'sd0 : a_e_ff;
      b_in.le_db = le_db;
      b_in.lt_db = lt_db;
      // separation only sees the error left after the deadband
      b_in.sep   = !zero_e && gt_il;
      b_in.pos   = !a_e_ff[31] && (a_e_ff != 32'sd0);
      b_in.neg   = a_e_ff[31];
   end

   // --------------------------------------------------------------- stage 4
   // items past this stage have not yet stored their drive, but it is clamped
   // to the present limit, so both weakening comparisons hold
   assign pending = |valid_ff[STAGES:4];
   assign dl_s    = $signed({1'b0, drive_limit_ff});
   assign ld_le   = pending || (last_drive_ff <= dl_s);
   assign ld_ge   = pending || (last_drive_ff >= -dl_s);
   assign acc     = ((ld_le && b_ff.pos) || (ld_ge && b_ff.neg)) && b_ff.lt_db;
   assign il_pos  = $signed(48'(integral_limit_ff));
   assign il_neg  = -il_pos;

   always_comb begin
      sum_base = (b_ff.cmd == pcv_pkg::CMD_PLAIN && b_ff.le_db) ? '0 : sum_ff;
      sum_add  = 49'(sum_base) + 49'($signed(b_ff.e));
      if (sum_add[48] != sum_add[47]) begin
         sum_sat = sum_add[48] ? pcv_pkg::SUM_MIN : pcv_pkg::SUM_MAX;
      end else begin
         sum_sat = sum_add[47:0];
      end
      sum_acc = (b_ff.cmd == pcv_pkg::CMD_WEAKEN && !acc) ? sum_ff : sum_sat;
      if (sum_acc > il_pos) begin
         sum_clip = il_pos;
      end else if (sum_acc < il_neg) begin
         sum_clip = il_neg;
      end else begin
         sum_clip = sum_acc;
      end
      unique case (pcv_pkg::cmd_type'(b_ff.cmd))
         pcv_pkg::CMD_PLAIN: begin
            isum_in = sum_sat;
            sum_in  = sum_sat;
         end
         pcv_pkg::CMD_SEPARATE: begin
            isum_in = b_ff.sep ? '0 : sum_sat;
            sum_in  = b_ff.sep ? '0 : sum_sat;
         end
         pcv_pkg::CMD_CLIP: begin
            isum_in = sum_clip;
            sum_in  = b_ff.lt_db ? '0 : sum_clip;
         end
         pcv_pkg::CMD_WEAKEN: begin
            isum_in = sum_clip;
            sum_in  = sum_clip;
         end
         default: begin
            isum_in = sum_clip;
            sum_in  = sum_clip;
         end
      endcase
   end

   assign de_in = 33'($signed(b_ff.e)) - 33'(last_error_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         last_error_ff <= '0;
      end else if (move[4] && valid_ff[3]) begin
         sum_ff        <= sum_in;
         last_error_ff <= b_ff.e;
      end
   end

   // --------------------------------------------------------------- stage 5
   assign p_mag32  = c_e_ff[31] ? (32'(~c_e_ff) + 32'd1) : 32'(c_e_ff);
   assign de_mag   = c_de_ff[32] ? (33'(~c_de_ff) + 33'd1) : 33'(c_de_ff);
   assign de_mag48 = pcv_pkg::MAG_W'(de_mag);

   always_comb begin
      d_mag_in[pcv_pkg::TERM_P]  = pcv_pkg::MAG_W'(p_mag32);
      d_sign_in[pcv_pkg::TERM_P] = c_e_ff[31];
      d_mag_in[pcv_pkg::TERM_I]  = c_isum_ff[47] ? (48'(~c_isum_ff) + 48'd1)
                                                 : 48'(c_isum_ff);
      d_sign_in[pcv_pkg::TERM_I] = c_isum_ff[47];
      // plain variant scales the difference by 500 = 512 - 8 - 4
      if (c_cmd_ff == pcv_pkg::CMD_PLAIN) begin
         d_mag_in[pcv_pkg::TERM_D] = (de_mag48 << 9) - (de_mag48 << 3) - (de_mag48 << 2);
      end else begin
         d_mag_in[pcv_pkg::TERM_D] = de_mag48;
      end
      d_sign_in[pcv_pkg::TERM_D] = c_de_ff[32];
   end

   // --------------------------------------------------------------- stage 6
   assign gain[pcv_pkg::TERM_P] = prop_gain_ff;
   assign gain[pcv_pkg::TERM_I] = integ_gain_ff;
   assign gain[pcv_pkg::TERM_D] = deriv_gain_ff;

   always_comb begin
      for (int k = 0; k < pcv_pkg::TERMS; k++) begin
         e_lo_in[k] = pcv_pkg::PROD_W'(d_mag_ff[k][pcv_pkg::HALF_W-1:0])
                      * pcv_pkg::PROD_W'(gain[k]);
         e_hi_in[k] = pcv_pkg::PROD_W'(d_mag_ff[k][pcv_pkg::MAG_W-1:pcv_pkg::HALF_W])
                      * pcv_pkg::PROD_W'(gain[k]);
      end
   end

   // --------------------------------------------------------------- stage 7
   assign lim[pcv_pkg::TERM_P]    = 64'(prop_term_limit_ff);
   assign lim[pcv_pkg::TERM_I]    = '0;
   assign lim[pcv_pkg::TERM_D]    = 64'(deriv_term_limit_ff);
   assign lim_on[pcv_pkg::TERM_P] = e_cmd_ff == pcv_pkg::CMD_CLIP
                                    || e_cmd_ff == pcv_pkg::CMD_WEAKEN;
   assign lim_on[pcv_pkg::TERM_I] = 1'b0;
   assign lim_on[pcv_pkg::TERM_D] = lim_on[pcv_pkg::TERM_P];

   always_comb begin
      logic [79:0] full;
      logic [63:0] prod;
      for (int k = 0; k < pcv_pkg::TERMS; k++) begin
         full = {e_hi_ff[k], 24'b0} + 80'(e_lo_ff[k]);
         // q16.16 product, rounded toward zero on the magnitude
         prod = full[79:16];
         // term limits sit below the cap, so both compares run in parallel
         if (lim_on[k] && prod > lim[k]) begin
            f_mag_in[k] = pcv_pkg::TMAG_W'(lim[k]);
         end else if (prod > pcv_pkg::TERM_CAP) begin
            f_mag_in[k] = pcv_pkg::TMAG_W'(pcv_pkg::TERM_CAP);
         end else begin
            f_mag_in[k] = pcv_pkg::TMAG_W'(prod);
         end
      end
   end

   // --------------------------------------------------------------- stage 8
   always_comb begin
      for (int k = 0; k < pcv_pkg::TERMS; k++) begin
         term_val[k] = f_sign_ff[k] ? -$signed({1'b0, f_mag_ff[k]})
                                    : $signed({1'b0, f_mag_ff[k]});
      end
      pi_sum = 64'(term_val[pcv_pkg::TERM_P]) + 64'(term_val[pcv_pkg::TERM_I]);
      if (pi_sum > pcv_pkg::TERM_CAP_S) begin
         g_pi_in = 63'(pcv_pkg::TERM_CAP_S);
      end else if (pi_sum < -pcv_pkg::TERM_CAP_S) begin
         g_pi_in = 63'(-pcv_pkg::TERM_CAP_S);
      end else begin
         g_pi_in = 63'(pi_sum);
      end
   end

   // -------------------------------------------------------- result stage
   // the last cap is covered by the drive clamp, which is always narrower
   assign drv_sum = 64'(g_pi_ff) + 64'(g_d_ff);
   assign drv_lim = 64'(dl_s);

   always_comb begin
      if (drv_sum > drv_lim) begin
         rsp_in.drive   = 32'(drv_lim);
         rsp_in.clamped = 1'b1;
      end else if (drv_sum < -drv_lim) begin
         rsp_in.drive   = 32'(-drv_lim);
         rsp_in.clamped = 1'b1;
      end else begin
         rsp_in.drive   = 32'(drv_sum);
         rsp_in.clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_drive_ff <= '0;
      end else if (move[STAGES+1] && valid_ff[STAGES]) begin
         last_drive_ff <= rsp_in.drive;
      end
   end

   // ------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (move[1]) begin
         req_ff <= req_payload;
      end
      if (move[2]) begin
         a_cmd_ff <= req_ff.cmd;
         a_e_ff   <= a_e_in;
      end
      if (move[3]) begin
         b_ff <= b_in;
      end
      if (move[4]) begin
         c_cmd_ff  <= b_ff.cmd;
         c_e_ff    <= b_ff.e;
         c_de_ff   <= de_in;
         c_isum_ff <= isum_in;
      end
      if (move[5]) begin
         d_cmd_ff  <= c_cmd_ff;
         d_mag_ff  <= d_mag_in;
         d_sign_ff <= d_sign_in;
      end
      if (move[6]) begin
         e_cmd_ff  <= d_cmd_ff;
         e_lo_ff   <= e_lo_in;
         e_hi_ff   <= e_hi_in;
         e_sign_ff <= d_sign_ff;
      end
      if (move[7]) begin
         f_mag_ff  <= f_mag_in;
         f_sign_ff <= e_sign_ff;
      end
      if (move[8]) begin
         g_pi_ff <= g_pi_in;
         g_d_ff  <= term_val[pcv_pkg::TERM_D];
      end
      if (move[STAGES+1]) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // a delivered drive never leaves the drive limit
   a_drive_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_payload.drive) <= dl_s
                     && $signed(rsp_payload.drive) >= -dl_s))
      else $error("drive outside drive limit");

   // a clamped drive sits exactly on one of the limits
   a_clamped_on_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.clamped) |->
         ($signed(rsp_payload.drive) == dl_s || $signed(rsp_payload.drive) == -dl_s))
      else $error("clamped drive not on the limit");

   // clip variant clears the sum after use inside the deadband
   a_clip_clears_sum: assert property (@(posedge clock) disable iff (reset)
      (move[4] && valid_ff[3] && b_ff.cmd == pcv_pkg::CMD_CLIP && b_ff.lt_db)
         |=> (sum_ff == '0))
      else $error("error sum not cleared inside deadband");

   // input is held off only when the whole pipeline is full behind a stalled result
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && (&valid_ff)))
      else $error("input stalled with room in the pipeline");
`endif

endmodule
